FILE: rtl/dpb_pkg.sv
package dpb_pkg;

  // default format parameters
  localparam int FRAC_BITS_DEF  = 16;
  localparam int DEPTH_BITS_DEF = 16;

  // fixed field widths
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;
  localparam int SAMP_W  = 16;
  localparam int PIX_W   = 12;
  localparam int COORD_W = 32;
  localparam int D_W     = 16;

  // register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_DEPTH_SCALE = 3'd0,
    REG_CENTER_X    = 3'd1,
    REG_CENTER_Y    = 3'd2,
    REG_FOCAL_X     = 3'd3,
    REG_FOCAL_Y     = 3'd4
  } reg_idx_t;

  // register reset values
  localparam logic [CFG_W-1:0] DEPTH_SCALE_RST = 16'd1000;
  localparam logic [CFG_W-1:0] CENTER_X_RST    = 16'd5120;
  localparam logic [CFG_W-1:0] CENTER_Y_RST    = 16'd3840;
  localparam logic [CFG_W-1:0] FOCAL_X_RST     = 16'd8192;
  localparam logic [CFG_W-1:0] FOCAL_Y_RST     = 16'd8192;

  // coordinate magnitude limits
  localparam logic [COORD_W-1:0] MAG_NEG_LIM = 32'h8000_0000;
  localparam logic [COORD_W-1:0] MAG_POS_LIM = 32'h7FFF_FFFF;

endpackage

FILE: rtl/dpb_ifs.sv
interface px_if import dpb_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SAMP_W-1:0] depth_sample;
  logic [PIX_W-1:0]  column;
  logic [PIX_W-1:0]  row;
  modport source (output valid, depth_sample, column, row, input ready);
  modport sink   (input valid, depth_sample, column, row, output ready);
endinterface

interface pt_if import dpb_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic                      point_valid;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic [COORD_W-1:0]        point_z;
  logic [COORD_W-1:0]        planar_range;
  logic [COORD_W-2:0]        half_height;
  modport source (output valid, point_valid, point_x, point_y, point_z, planar_range,
                  half_height, input ready);
  modport sink   (input valid, point_valid, point_x, point_y, point_z, planar_range,
                  half_height, output ready);
endinterface

interface cfg_if import dpb_pkg::*;;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/dpb_div.sv
module dpb_div #(
  parameter int NUM_W  = 40,
  parameter int DEN_W  = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  quo,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld [0:NUM_W];
  logic [DEN_W-1:0]  rem [0:NUM_W];
  logic [NUM_W-1:0]  acc [0:NUM_W];
  logic [DEN_W-1:0]  dv  [0:NUM_W];
  logic [SIDE_W-1:0] sd  [0:NUM_W];

  // stage zero is the incoming request
  assign vld[0] = in_valid;
  assign rem[0] = '0;
  assign acc[0] = num;
  assign dv[0]  = den;
  assign sd[0]  = side;

  // one restoring quotient bit per stage
  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [DEN_W:0] t;
    logic           ge;

    assign t  = {rem[s], acc[s][NUM_W-1]};
    assign ge = t >= {1'b0, dv[s]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
      if (en) begin
        rem[s+1] <= ge ? DEN_W'(t - {1'b0, dv[s]}) : t[DEN_W-1:0];
        acc[s+1] <= {acc[s][NUM_W-2:0], ge};
        dv[s+1]  <= dv[s];
        sd[s+1]  <= sd[s];
      end
    end
  end

  assign out_valid = vld[NUM_W];
  assign quo       = acc[NUM_W];
  assign out_side  = sd[NUM_W];

endmodule

FILE: rtl/dpb_isqrt.sv
module dpb_isqrt #(
  parameter int ROOT_W = 32,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2*ROOT_W-1:0] rad_in,
  input  logic [SIDE_W-1:0]   side,
  output logic                out_valid,
  output logic [ROOT_W-1:0]   root_out,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int RAD_W = 2 * ROOT_W;

  logic              vld  [0:ROOT_W];
  logic [ROOT_W:0]   rem  [0:ROOT_W];
  logic [ROOT_W-1:0] root [0:ROOT_W];
  logic [RAD_W-1:0]  rad  [0:ROOT_W];
  logic [SIDE_W-1:0] sd   [0:ROOT_W];

  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign rad[0]  = rad_in;
  assign sd[0]   = side;

  // one root bit per stage, two radicand bits brought down each time
  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic [ROOT_W+1:0] t;
    logic [ROOT_W+1:0] trial;
    logic              ge;

    assign t     = {rem[s][ROOT_W-1:0], rad[s][RAD_W-1:RAD_W-2]};
    assign trial = {root[s], 2'b01};
    assign ge    = t >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
      if (en) begin
        rem[s+1]  <= ge ? (ROOT_W+1)'(t - trial) : t[ROOT_W:0];
        root[s+1] <= {root[s][ROOT_W-2:0], ge};
        rad[s+1]  <= {rad[s][RAD_W-3:0], 2'b00};
        sd[s+1]   <= sd[s];
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign root_out  = root[ROOT_W];
  assign out_side  = sd[ROOT_W];

endmodule

FILE: rtl/depth_pixel_backprojection.sv
// channel  modport  carries
// -------  -------  ---------------------------------------------------------
// cfg      sink     register index and 16-bit write data, always ready
// pix      sink     depth_sample, column, row
// pt       source   point_valid, point_x, point_y, point_z, planar_range,
//                   half_height
//
// one pixel per cycle while pt is not stalled; the path runs through the
// bit-per-stage depth divider, the 48-stage focal dividers and the 32-stage
// square root. every stage moves together and holds while pt is stalled, so
// pix.ready follows pt.ready. synchronous reset clears the valid bits and
// loads the register defaults; no clearing pass.
module depth_pixel_backprojection import dpb_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
  input logic clk,
  input logic rst,
  cfg_if.sink cfg,
  px_if.sink  pix,
  pt_if.source pt
);

  localparam int ZN_W = DEPTH_BITS + FRAC_BITS;
  localparam int P_W  = D_W + COORD_W;
  localparam int S1_W = 1 + 2 * PIX_W;
  localparam int SX_W = 2 + COORD_W;
  localparam int SQ_W = 1 + 3 * COORD_W;

  logic [CFG_W-1:0] depth_scale, center_x, center_y, focal_x, focal_y;
  logic [CFG_W-1:0] scale_eff, fx_eff, fy_eff;
  logic             en;

  // configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_scale <= DEPTH_SCALE_RST;
      center_x    <= CENTER_X_RST;
      center_y    <= CENTER_Y_RST;
      focal_x     <= FOCAL_X_RST;
      focal_y     <= FOCAL_Y_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DEPTH_SCALE: depth_scale <= cfg.data;
        REG_CENTER_X:    center_x    <= cfg.data;
        REG_CENTER_Y:    center_y    <= cfg.data;
        REG_FOCAL_X:     focal_x     <= cfg.data;
        REG_FOCAL_Y:     focal_y     <= cfg.data;
        default: ;
      endcase
    end
  end

  assign scale_eff = (depth_scale == '0) ? CFG_W'(1) : depth_scale;
  assign fx_eff    = (focal_x == '0) ? CFG_W'(1) : focal_x;
  assign fy_eff    = (focal_y == '0) ? CFG_W'(1) : focal_y;

  // whole pipeline advances unless the output is held
  assign en        = !pt.valid || pt.ready;
  assign pix.ready = en;

  // depth divider: z = (depth << FRAC_BITS) / scale
  logic [DEPTH_BITS-1:0] depth_m;
  logic                  v1;
  logic [ZN_W-1:0]       q1;
  logic [S1_W-1:0]       s1;

  assign depth_m = pix.depth_sample[DEPTH_BITS-1:0];

  dpb_div #(.NUM_W(ZN_W), .DEN_W(CFG_W), .SIDE_W(S1_W)) u_zdiv (
    .clk, .rst, .en,
    .in_valid  (pix.valid),
    .num       ({depth_m, {FRAC_BITS{1'b0}}}),
    .den       (scale_eff),
    .side      ({|depth_m, pix.column, pix.row}),
    .out_valid (v1),
    .quo       (q1),
    .out_side  (s1)
  );

  // stage a: saturate z, signed offsets from the principal point
  logic [63:0]        q1w;
  logic [D_W-1:0]     pos_x, pos_y;
  logic               va, a_nz, a_nx, a_ny;
  logic [COORD_W-1:0] a_z;
  logic [D_W-1:0]     a_dx, a_dy;

  assign q1w   = 64'(q1);
  assign pos_x = {s1[2*PIX_W-1:PIX_W], 4'b0000};
  assign pos_y = {s1[PIX_W-1:0], 4'b0000};

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= v1;
    end
    if (en) begin
      a_nz <= s1[S1_W-1];
      a_z  <= (|q1w[63:COORD_W]) ? '1 : q1w[COORD_W-1:0];
      a_nx <= pos_x < center_x;
      a_dx <= (pos_x < center_x) ? center_x - pos_x : pos_x - center_x;
      a_ny <= pos_y < center_y;
      a_dy <= (pos_y < center_y) ? center_y - pos_y : pos_y - center_y;
    end
  end

  // stage b: offset times z
  logic               vb, b_nz, b_nx, b_ny;
  logic [COORD_W-1:0] b_z;
  logic [P_W-1:0]     b_px, b_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
    if (en) begin
      b_nz <= a_nz;
      b_nx <= a_nx;
      b_ny <= a_ny;
      b_z  <= a_z;
      b_px <= P_W'(a_dx) * P_W'(a_z);
      b_py <= P_W'(a_dy) * P_W'(a_z);
    end
  end

  // focal dividers for x and y in lockstep
  logic            v2, v2y;
  logic [P_W-1:0]  qx, qy;
  logic [SX_W-1:0] s2x;
  logic            s2y;

  dpb_div #(.NUM_W(P_W), .DEN_W(CFG_W), .SIDE_W(SX_W)) u_xdiv (
    .clk, .rst, .en,
    .in_valid  (vb),
    .num       (b_px),
    .den       (fx_eff),
    .side      ({b_nz, b_nx, b_z}),
    .out_valid (v2),
    .quo       (qx),
    .out_side  (s2x)
  );

  dpb_div #(.NUM_W(P_W), .DEN_W(CFG_W), .SIDE_W(1)) u_ydiv (
    .clk, .rst, .en,
    .in_valid  (vb),
    .num       (b_py),
    .den       (fy_eff),
    .side      (b_ny),
    .out_valid (v2y),
    .quo       (qy),
    .out_side  (s2y)
  );

  function automatic logic [COORD_W-1:0] sat_mag(input logic [P_W-1:0] q, input logic neg);
    logic [P_W-1:0] lim;
    lim = neg ? P_W'(MAG_NEG_LIM) : P_W'(MAG_POS_LIM);
    return (q > lim) ? lim[COORD_W-1:0] : q[COORD_W-1:0];
  endfunction

  // stage c: saturate magnitudes and apply signs
  logic               vc, c_nz;
  logic [COORD_W-1:0] c_z, c_mx, c_my, c_x, c_y;
  logic [COORD_W-1:0] mx_n, my_n;

  assign mx_n = sat_mag(qx, s2x[COORD_W]);
  assign my_n = sat_mag(qy, s2y);

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= v2;
    end
    if (en) begin
      c_nz <= s2x[SX_W-1];
      c_z  <= s2x[COORD_W-1:0];
      c_mx <= mx_n;
      c_my <= my_n;
      c_x  <= s2x[COORD_W] ? COORD_W'(-mx_n) : mx_n;
      c_y  <= s2y ? COORD_W'(-my_n) : my_n;
    end
  end

  // stage d: squares
  logic                 vd, d_nz;
  logic [COORD_W-1:0]   d_z, d_x, d_y;
  logic [2*COORD_W-1:0] d_sx, d_sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en) begin
      vd <= vc;
    end
    if (en) begin
      d_nz <= c_nz;
      d_z  <= c_z;
      d_x  <= c_x;
      d_y  <= c_y;
      d_sx <= {{COORD_W{1'b0}}, c_mx} * {{COORD_W{1'b0}}, c_mx};
      d_sy <= {{COORD_W{1'b0}}, c_my} * {{COORD_W{1'b0}}, c_my};
    end
  end

  // stage e: sum of squares
  logic                 ve, e_nz;
  logic [COORD_W-1:0]   e_z, e_x, e_y;
  logic [2*COORD_W-1:0] e_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (en) begin
      ve <= vd;
    end
    if (en) begin
      e_nz  <= d_nz;
      e_z   <= d_z;
      e_x   <= d_x;
      e_y   <= d_y;
      e_sum <= d_sx + d_sy;
    end
  end

  // planar range
  logic               v3;
  logic [COORD_W-1:0] r3;
  logic [SQ_W-1:0]    s3;

  dpb_isqrt #(.ROOT_W(COORD_W), .SIDE_W(SQ_W)) u_sqrt (
    .clk, .rst, .en,
    .in_valid  (ve),
    .rad_in    (e_sum),
    .side      ({e_nz, e_x, e_y, e_z}),
    .out_valid (v3),
    .root_out  (r3),
    .out_side  (s3)
  );

  // output register
  logic               vo, o_nz;
  logic [COORD_W-1:0] o_x, o_y, o_z, o_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= v3;
    end
    if (en) begin
      o_nz <= s3[SQ_W-1];
      o_x  <= s3[3*COORD_W-1:2*COORD_W];
      o_y  <= s3[2*COORD_W-1:COORD_W];
      o_z  <= s3[COORD_W-1:0];
      o_r  <= r3;
    end
  end

  assign pt.valid        = vo;
  assign pt.point_valid  = o_nz;
  assign pt.point_x      = o_x;
  assign pt.point_y      = o_y;
  assign pt.point_z      = o_z;
  assign pt.planar_range = o_r;
  assign pt.half_height  = o_z[COORD_W-1:1];

  // checks
  logic [COORD_W-1:0] abs_x, abs_y;

  assign abs_x = o_x[COORD_W-1] ? COORD_W'(-o_x) : o_x;
  assign abs_y = o_y[COORD_W-1] ? COORD_W'(-o_y) : o_y;

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    pt.valid && !pt.point_valid |-> o_x == '0 && o_y == '0 && o_z == '0 && o_r == '0)
    else $error("invalid point carries nonzero fields");

  a_range_x: assert property (@(posedge clk) disable iff (rst)
    pt.valid |-> pt.planar_range >= abs_x)
    else $error("planar range below lateral magnitude");

  a_range_y: assert property (@(posedge clk) disable iff (rst)
    pt.valid |-> pt.planar_range >= abs_y)
    else $error("planar range below vertical magnitude");

  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    pt.valid && !pt.ready |-> !pix.ready)
    else $error("input taken while output held");

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    v2y == v2)
    else $error("focal dividers out of step");

endmodule

FILE: test/tb.sv
module tb import dpb_pkg::*;;

  localparam int LATENCY   = DEPTH_BITS_DEF + FRAC_BITS_DEF + 86;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [SAMP_W-1:0] depth_sample;
    logic [PIX_W-1:0]  column;
    logic [PIX_W-1:0]  row;
  } pixel_t;

  typedef struct packed {
    logic                      point_valid;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [COORD_W-1:0]        point_z;
    logic [COORD_W-1:0]        planar_range;
    logic [COORD_W-2:0]        half_height;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cfg_if cfg ();
  px_if  pix ();
  pt_if  pt ();

  depth_pixel_backprojection uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .pix (pix),
    .pt  (pt)
  );

  // camera registers as the predictor sees them
  logic [CFG_W-1:0] cam_scale = DEPTH_SCALE_RST;
  logic [CFG_W-1:0] cam_cx    = CENTER_X_RST;
  logic [CFG_W-1:0] cam_cy    = CENTER_Y_RST;
  logic [CFG_W-1:0] cam_fx    = FOCAL_X_RST;
  logic [CFG_W-1:0] cam_fy    = FOCAL_Y_RST;

  pixel_t pending_pixels[$];
  point_t expected_points[$];
  int     error_count = 0;
  int     points_seen = 0;
  int     idle_cycles = 0;
  int     send_gap = 0;
  int     take_gap = 0;
  bit     hold_pixels = 1'b0;

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // integer square root by digit recurrence
  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // one axis of the pinhole projection, magnitude returned through mag
  function automatic logic [31:0] axis_coord(logic [PIX_W-1:0] pixel, logic [CFG_W-1:0] centre,
                                             logic [CFG_W-1:0] focal, logic [31:0] z,
                                             output logic [63:0] mag);
    logic [63:0] pos;
    logic [63:0] offset;
    logic [63:0] q;
    logic [63:0] f;
    bit          neg;
    pos    = {48'd0, pixel, 4'd0};
    neg    = pos < centre;
    offset = neg ? centre - pos : pos - centre;
    f      = (focal == 0) ? 64'd1 : focal;
    q      = (offset * z) / f;
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      mag = q;
      return 32'(64'h1_0000_0000 - q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    mag = q;
    return q[31:0];
  endfunction

  function automatic point_t backproject(pixel_t p);
    point_t      o;
    logic [63:0] z;
    logic [63:0] s;
    logic [63:0] mx;
    logic [63:0] my;
    logic [63:0] r;
    o = '0;
    if (p.depth_sample == 0) return o;
    s = (cam_scale == 0) ? 64'd1 : cam_scale;
    z = ({48'd0, p.depth_sample} << FRAC_BITS_DEF) / s;
    if (z > 64'hFFFF_FFFF) z = 64'hFFFF_FFFF;
    o.point_valid = 1'b1;
    o.point_x     = axis_coord(p.column, cam_cx, cam_fx, z[31:0], mx);
    o.point_y     = axis_coord(p.row, cam_cy, cam_fy, z[31:0], my);
    o.point_z     = z[31:0];
    r = root_floor(mx * mx + my * my);
    if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
    o.planar_range = r[31:0];
    o.half_height  = z[31:1];
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on point %0d: %s got %0h expected %0h", points_seen, what, got, want);
    error_count++;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg.index <= idx;
    cfg.data  <= val;
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      REG_DEPTH_SCALE: cam_scale = val;
      REG_CENTER_X:    cam_cx    = val;
      REG_CENTER_Y:    cam_cy    = val;
      REG_FOCAL_X:     cam_fx    = val;
      REG_FOCAL_Y:     cam_fy    = val;
      default: ;
    endcase
  endtask

  // wait for the pipeline to empty so registers can change
  task automatic drain();
    while (pending_pixels.size() != 0 || expected_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic queue_pixel(logic [15:0] d, logic [11:0] c, logic [11:0] r);
    pixel_t p;
    p.depth_sample = d;
    p.column       = c;
    p.row          = r;
    pending_pixels = {pending_pixels, p};
  endtask

  function automatic logic [15:0] rand_depth();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return 16'd0;
    if (k == 1) return 16'hFFFF;
    if (k < 6) return 16'($urandom_range(1, 15));
    return 16'($urandom);
  endfunction

  task automatic random_phase(int n);
    repeat (n) queue_pixel(rand_depth(), 12'($urandom), 12'($urandom));
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
    end else if (pix.valid && !pix.ready) begin
      // hold the offered pixel
    end else begin
      if (pix.valid && pix.ready) begin
        expected_points = {expected_points, backproject(pending_pixels.pop_front())};
      end
      if (send_gap > 0) begin
        send_gap  <= send_gap - 1;
        pix.valid <= 1'b0;
      end else if (!hold_pixels && pending_pixels.size() != 0) begin
        pix.valid        <= 1'b1;
        pix.depth_sample <= pending_pixels[0].depth_sample;
        pix.column       <= pending_pixels[0].column;
        pix.row          <= pending_pixels[0].row;
        send_gap         <= pick_gap();
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  // monitor and back-pressure
  always @(posedge clk) begin
    point_t want;
    if (rst) begin
      pt.ready <= 1'b0;
    end else begin
      if (pt.valid && pt.ready) begin
        if (expected_points.size() == 0) begin
          $display("unexpected point %0d", points_seen);
          error_count++;
        end else begin
          want = expected_points.pop_front();
          if (pt.point_valid !== want.point_valid)
            report_mismatch("point_valid", pt.point_valid, want.point_valid);
          if (pt.point_x !== want.point_x) report_mismatch("point_x", pt.point_x, want.point_x);
          if (pt.point_y !== want.point_y) report_mismatch("point_y", pt.point_y, want.point_y);
          if (pt.point_z !== want.point_z) report_mismatch("point_z", pt.point_z, want.point_z);
          if (pt.planar_range !== want.planar_range)
            report_mismatch("planar_range", pt.planar_range, want.planar_range);
          if (pt.half_height !== want.half_height)
            report_mismatch("half_height", pt.half_height, want.half_height);
        end
        points_seen++;
      end
      if (take_gap > 0) begin
        take_gap <= take_gap - 1;
        pt.ready <= 1'b0;
      end else begin
        pt.ready <= 1'b1;
        take_gap <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  // watchdog on cycles with no request or point accepted
  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (pt.valid && pt.ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT + 40 * LATENCY) begin
      $display("depth_pixel_backprojection regression: fail");
      $finish;
    end
  end

  initial begin
    cfg.valid = 1'b0;
    cfg.index = REG_DEPTH_SCALE;
    cfg.data  = '0;
    pix.valid = 1'b0;
    pix.depth_sample = '0;
    pix.column = '0;
    pix.row = '0;
    pt.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset defaults, field extremes and zero depth
    queue_pixel(16'd0, 12'd100, 12'd100);
    queue_pixel(16'hFFFF, 12'd0, 12'd0);
    queue_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
    queue_pixel(16'd1, 12'd320, 12'd240);
    queue_pixel(16'd1000, 12'd320, 12'd240);
    queue_pixel(16'd1500, 12'hFFF, 12'd0);
    queue_pixel(16'h8000, 12'h800, 12'h7FF);
    queue_pixel(16'd0, 12'hFFF, 12'hFFF);
    drain();

    // saturation: unit scale and focal, centre at the top
    write_reg(REG_DEPTH_SCALE, 16'd1);
    write_reg(REG_FOCAL_X, 16'd1);
    write_reg(REG_FOCAL_Y, 16'd1);
    write_reg(REG_CENTER_X, 16'hFFFF);
    write_reg(REG_CENTER_Y, 16'd0);
    queue_pixel(16'hFFFF, 12'd0, 12'hFFF);
    queue_pixel(16'hFFFF, 12'hFFF, 12'd0);
    queue_pixel(16'd1, 12'd0, 12'd0);
    queue_pixel(16'd0, 12'd0, 12'd0);
    random_phase(100);
    drain();

    // zero scale and zero focal read as one
    write_reg(REG_DEPTH_SCALE, 16'd0);
    write_reg(REG_FOCAL_X, 16'd0);
    write_reg(REG_FOCAL_Y, 16'hFFFF);
    write_reg(REG_CENTER_X, 16'd0);
    write_reg(REG_CENTER_Y, 16'hFFFF);
    queue_pixel(16'hFFFF, 12'hFFF, 12'd0);
    queue_pixel(16'd7, 12'd5, 12'd9);
    random_phase(100);
    drain();

    // largest scale and x focal, zero y focal
    write_reg(REG_DEPTH_SCALE, 16'hFFFF);
    write_reg(REG_FOCAL_X, 16'hFFFF);
    write_reg(REG_FOCAL_Y, 16'd0);
    random_phase(100);

    // sender holds until every point has come back
    hold_pixels = 1'b1;
    while (expected_points.size() != 0 || pix.valid) @(posedge clk);
    hold_pixels = 1'b0;
    drain();

    // random camera settings
    repeat (3) begin
      write_reg(REG_DEPTH_SCALE, 16'($urandom));
      write_reg(REG_CENTER_X, 16'($urandom));
      write_reg(REG_CENTER_Y, 16'($urandom));
      write_reg(REG_FOCAL_X, 16'($urandom));
      write_reg(REG_FOCAL_Y, 16'($urandom));
      random_phase(100);
      drain();
    end

    $display("covered %0d points over seven camera settings, incl. zero depth,", points_seen);
    $display("saturated coordinates, zero scale and zero focal lengths");
    if (error_count == 0) begin
      $display("depth_pixel_backprojection regression: pass");
    end else begin
      $display("depth_pixel_backprojection regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/dpb_pkg.sv
rtl/dpb_ifs.sv
rtl/dpb_div.sv
rtl/dpb_isqrt.sv
rtl/depth_pixel_backprojection.sv
test/tb.sv
